@@ hw/rtl/slcenc_pkg.sv @@
package slcenc_pkg;

  localparam int unsigned MAX_DATA_BYTES = 8;
  localparam int unsigned CountW         = 4;
  localparam int unsigned StepW          = 4;

  // program addresses used as jump targets
  localparam logic [StepW-1:0] STEP_STD_IDENT = 4'd6;
  localparam logic [StepW-1:0] STEP_DATA      = 4'd10;
  localparam logic [StepW-1:0] STEP_CR        = 4'd12;
  localparam logic [StepW-1:0] STEP_LAST      = STEP_CR;

  localparam logic [7:0] CHAR_STD_DATA = 8'h74;  // 't'
  localparam logic [7:0] CHAR_STD_RTR  = 8'h72;  // 'r'
  localparam logic [7:0] CHAR_EXT_DATA = 8'h54;  // 'T'
  localparam logic [7:0] CHAR_EXT_RTR  = 8'h52;  // 'R'
  localparam logic [7:0] CHAR_CR       = 8'h0D;

  typedef enum logic [2:0] {
    OP_TYPE,
    OP_IDENT,
    OP_LEN,
    OP_DATA_HI,
    OP_DATA_LO,
    OP_CR
  } op_e;

  typedef enum logic [1:0] {
    JC_NONE,
    JC_STD,
    JC_NODATA,
    JC_MORE
  } cond_e;

  typedef struct packed {
    op_e              op;
    logic [2:0]       nib;
    cond_e            cond;
    logic [StepW-1:0] target;
    logic             last;
  } ctrl_word_t;

  typedef struct packed {
    logic is_std;
    logic no_data;
    logic more;
  } dp_status_t;

  function automatic ctrl_word_t ucode(input logic [StepW-1:0] step);
    ctrl_word_t cw;
    cw = '{op: OP_CR, nib: 3'd0, cond: JC_NONE, target: STEP_CR, last: 1'b1};
    unique case (step)
      4'd0:  cw = '{OP_TYPE,    3'd0, JC_STD,    STEP_STD_IDENT, 1'b0};
      4'd1:  cw = '{OP_IDENT,   3'd7, JC_NONE,   STEP_CR,        1'b0};
      4'd2:  cw = '{OP_IDENT,   3'd6, JC_NONE,   STEP_CR,        1'b0};
      4'd3:  cw = '{OP_IDENT,   3'd5, JC_NONE,   STEP_CR,        1'b0};
      4'd4:  cw = '{OP_IDENT,   3'd4, JC_NONE,   STEP_CR,        1'b0};
      4'd5:  cw = '{OP_IDENT,   3'd3, JC_NONE,   STEP_CR,        1'b0};
      4'd6:  cw = '{OP_IDENT,   3'd2, JC_NONE,   STEP_CR,        1'b0};
      4'd7:  cw = '{OP_IDENT,   3'd1, JC_NONE,   STEP_CR,        1'b0};
      4'd8:  cw = '{OP_IDENT,   3'd0, JC_NONE,   STEP_CR,        1'b0};
      4'd9:  cw = '{OP_LEN,     3'd0, JC_NODATA, STEP_CR,        1'b0};
      4'd10: cw = '{OP_DATA_HI, 3'd0, JC_NONE,   STEP_CR,        1'b0};
      4'd11: cw = '{OP_DATA_LO, 3'd0, JC_MORE,   STEP_DATA,      1'b0};
      4'd12: cw = '{OP_CR,      3'd0, JC_NONE,   STEP_CR,        1'b1};
      default: cw = '{OP_CR,    3'd0, JC_NONE,   STEP_CR,        1'b1};
    endcase
    return cw;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h37 + {4'd0, nib};
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/slcenc_datapath.sv @@
module slcenc_datapath (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  logic                                is_extended_i,
  input  logic                                is_remote_i,
  input  logic [28:0]                         ident_i,
  input  logic [3:0]                          byte_count_i,
  input  logic [63:0]                         payload_i,
  input  logic                                advance_i,
  input  slcenc_pkg::ctrl_word_t              cw_i,
  output logic [7:0]                          char_o,
  output slcenc_pkg::dp_status_t              status_o
);

  logic [31:0]                    ident_q;
  logic                           ext_q;
  logic                           rtr_q;
  logic [slcenc_pkg::CountW-1:0]  len_q;
  logic [slcenc_pkg::CountW-1:0]  remain_q;
  logic [63:0]                    data_q;
  logic [slcenc_pkg::CountW-1:0]  len_clamped;
  logic [3:0]                     id_nib;

  localparam logic [slcenc_pkg::CountW-1:0] MaxBytes =
    slcenc_pkg::CountW'(slcenc_pkg::MAX_DATA_BYTES);

  assign len_clamped = (byte_count_i > MaxBytes) ? MaxBytes : byte_count_i;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      // standard frames carry only the low eleven identifier bits
      ident_q  <= is_extended_i ? {3'd0, ident_i} : {21'd0, ident_i[10:0]};
      ext_q    <= is_extended_i;
      rtr_q    <= is_remote_i;
      len_q    <= len_clamped;
      remain_q <= len_clamped;
      data_q   <= payload_i;
    end else if (advance_i && cw_i.op == slcenc_pkg::OP_DATA_LO) begin
      remain_q <= remain_q - 1'b1;
      data_q   <= {data_q[55:0], 8'd0};
    end
  end

  assign id_nib = ident_q[{cw_i.nib, 2'b00} +: 4];

  always_comb begin
    char_o = slcenc_pkg::CHAR_CR;
    case (cw_i.op)
      slcenc_pkg::OP_TYPE: begin
        if (ext_q) begin
          char_o = rtr_q ? slcenc_pkg::CHAR_EXT_RTR : slcenc_pkg::CHAR_EXT_DATA;
        end else begin
          char_o = rtr_q ? slcenc_pkg::CHAR_STD_RTR : slcenc_pkg::CHAR_STD_DATA;
        end
      end
      slcenc_pkg::OP_IDENT:   char_o = slcenc_pkg::hex_char(id_nib);
      slcenc_pkg::OP_LEN:     char_o = slcenc_pkg::hex_char(len_q);
      slcenc_pkg::OP_DATA_HI: char_o = slcenc_pkg::hex_char(data_q[63:60]);
      slcenc_pkg::OP_DATA_LO: char_o = slcenc_pkg::hex_char(data_q[59:56]);
      default:                char_o = slcenc_pkg::CHAR_CR;
    endcase
  end

  assign status_o.is_std  = ~ext_q;
  assign status_o.no_data = (len_q == '0);
  assign status_o.more    = (remain_q > slcenc_pkg::CountW'(1));

endmodule

@@ hw/rtl/slcan_frame_encoder.sv @@
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_ready_o   | is_extended, is_remote, ident,
//         |           |                        | byte_count, payload
// out     | output    | out_valid_o / out_ready_i | out_char, last_char (per word)
//
// One character word per step of a 13-step control program, which starts once the
// message is taken: with n the clamped byte count, a message yields 6 + 2n (standard)
// or 11 + 2n (extended) words, at most 27.
// A new message is taken once the carriage return step has run, while that
// last word may still wait in the output register.
// A stalled output holds the program step; reset clears the sequencer state.
module slcan_frame_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        is_extended_i,
  input  logic        is_remote_i,
  input  logic [28:0] ident_i,
  input  logic [3:0]  byte_count_i,
  input  logic [63:0] payload_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_char_o,
  output logic        last_char_o
);

  logic                               busy_q, busy_d;
  logic [slcenc_pkg::StepW-1:0]       step_q, step_d;
  logic                               out_valid_q, out_valid_d;
  logic [7:0]                         out_char_q;
  logic                               out_last_q;
  logic                               load;
  logic                               advance;
  logic                               jump;
  logic [7:0]                         dp_char;
  slcenc_pkg::ctrl_word_t             cw;
  slcenc_pkg::dp_status_t             status;

  assign cw         = slcenc_pkg::ucode(step_q);
  assign in_ready_o = ~busy_q;
  assign load       = in_valid_i & ~busy_q;
  assign advance    = busy_q & (~out_valid_q | out_ready_i);

  slcenc_datapath u_datapath (
    .clk_i         (clk_i),
    .load_i        (load),
    .is_extended_i (is_extended_i),
    .is_remote_i   (is_remote_i),
    .ident_i       (ident_i),
    .byte_count_i  (byte_count_i),
    .payload_i     (payload_i),
    .advance_i     (advance),
    .cw_i          (cw),
    .char_o        (dp_char),
    .status_o      (status)
  );

  always_comb begin
    unique case (cw.cond)
      slcenc_pkg::JC_STD:    jump = status.is_std;
      slcenc_pkg::JC_NODATA: jump = status.no_data;
      slcenc_pkg::JC_MORE:   jump = status.more;
      default:               jump = 1'b0;
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (advance) begin
      out_valid_d = 1'b1;
      step_d      = jump ? cw.target : step_q + 1'b1;
      // drop busy after the carriage return
      if (cw.last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_char_q <= dp_char;
      out_last_q <= cw.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = out_last_q;

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (busy_q && step_q == '0))
    else $error("message accepted without restarting the program");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (step_q <= slcenc_pkg::STEP_LAST))
    else $error("program step out of range");

  a_cr_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && cw.last) |=> (!busy_q && out_valid_q && out_last_q
                              && out_char_q == slcenc_pkg::CHAR_CR))
    else $error("carriage return did not close the message");

  a_no_adv_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && busy_q) |=> $stable(step_q))
    else $error("program advanced under a stalled output");

endmodule
